// ===== design/sidc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sidc_pkg;

    localparam int COORD_W    = 32;
    localparam int DIFF_W     = 33;
    localparam int PROD_W     = 66;
    localparam int CROSS_W    = 67;
    localparam int MAG_W      = 66;
    localparam int NUM_W      = 98;
    localparam int QUO_W      = 32;
    localparam int DIV_STEPS  = 32;
    localparam int SQ_IN_W    = 65;
    localparam int ROOT_W     = 33;
    localparam int REM_W      = 35;
    localparam int SQRT_STEPS = 33;
    localparam int RAD_W      = 2 * SQRT_STEPS;
    localparam int DIST_W     = 32;
    localparam int THR_W      = 32;
    localparam int ADDR_W     = 3;

    localparam logic [0:0]       REG_DET_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0] THR_RESET         = 32'd4;

    typedef enum logic [1:0] {
        ST_HIT      = 2'd0,
        ST_PARALLEL = 2'd1,
        ST_OUTSIDE  = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COORD_W-1:0] path_start_x;
        logic signed [COORD_W-1:0] path_start_y;
        logic signed [COORD_W-1:0] path_end_x;
        logic signed [COORD_W-1:0] path_end_y;
        logic signed [COORD_W-1:0] edge_start_x;
        logic signed [COORD_W-1:0] edge_start_y;
        logic signed [COORD_W-1:0] edge_end_x;
        logic signed [COORD_W-1:0] edge_end_y;
    } t_in_item;

    typedef struct packed {
        t_status                   status;
        logic [DIST_W-1:0]         hit_distance;
        logic signed [COORD_W-1:0] cross_x;
        logic signed [COORD_W-1:0] cross_y;
    } t_out_item;

    typedef struct packed {
        t_status              status;
        logic [COORD_W-1:0]   p0x;
        logic [COORD_W-1:0]   p0y;
        logic                 dx_neg;
        logic                 dy_neg;
    } t_div_tag;

    typedef struct packed {
        t_status              status;
        logic [COORD_W-1:0]   cross_x;
        logic [COORD_W-1:0]   cross_y;
    } t_sqrt_tag;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] qn;
    } t_div_st;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
    } t_sqrt_st;

    // one restoring step: shift in the next numerator bit, subtract if it fits
    function automatic t_div_st div_step(t_div_st s, logic [MAG_W-1:0] den);
        logic [MAG_W:0] t;
        logic [MAG_W:0] dif;
        t_div_st        r;
        t   = {s.rem, s.qn[QUO_W-1]};
        dif = t - {1'b0, den};
        if (t >= {1'b0, den}) begin
            r.rem = dif[MAG_W-1:0];
            r.qn  = {s.qn[QUO_W-2:0], 1'b1};
        end else begin
            r.rem = t[MAG_W-1:0];
            r.qn  = {s.qn[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // one digit-by-digit root step over the next radicand bit pair
    function automatic t_sqrt_st sqrt_step(t_sqrt_st s);
        logic [REM_W+1:0] t;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] dif;
        t_sqrt_st         r;
        t     = {s.rem, s.rad[RAD_W-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        dif   = t - trial;
        r.rad = {s.rad[RAD_W-3:0], 2'b00};
        if (t >= trial) begin
            r.rem  = dif[REM_W-1:0];
            r.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = t[REM_W-1:0];
            r.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/sidc_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sidc_div (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_en,
    input  wire                          i_valid,
    input  wire [sidc_pkg::NUM_W-1:0]    i_num_x,
    input  wire [sidc_pkg::NUM_W-1:0]    i_num_y,
    input  wire [sidc_pkg::MAG_W-1:0]    i_den,
    input  sidc_pkg::t_div_tag           i_tag,
    output logic                         o_valid,
    output logic [sidc_pkg::QUO_W-1:0]   o_quo_x,
    output logic [sidc_pkg::QUO_W-1:0]   o_quo_y,
    output sidc_pkg::t_div_tag           o_tag
);
    import sidc_pkg::*;

    // quotient is known to fit QUO_W bits, so the top bits seed the remainder
    logic     r_v   [DIV_STEPS];
    t_div_st  r_x   [DIV_STEPS];
    t_div_st  r_y   [DIV_STEPS];
    logic [MAG_W-1:0] r_den [DIV_STEPS];
    t_div_tag r_tag [DIV_STEPS];

    t_div_st seed_x;
    t_div_st seed_y;
    assign seed_x = '{rem: i_num_x[NUM_W-1:QUO_W], qn: i_num_x[QUO_W-1:0]};
    assign seed_y = '{rem: i_num_y[NUM_W-1:QUO_W], qn: i_num_y[QUO_W-1:0]};

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= i_valid;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k]   <= div_step(seed_x, i_den);
                    r_y[k]   <= div_step(seed_y, i_den);
                    r_den[k] <= i_den;
                    r_tag[k] <= i_tag;
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[k]   <= div_step(r_x[k-1], r_den[k-1]);
                    r_y[k]   <= div_step(r_y[k-1], r_den[k-1]);
                    r_den[k] <= r_den[k-1];
                    r_tag[k] <= r_tag[k-1];
                end
            end
        end
    end

    // round to nearest: bump when twice the remainder reaches the divisor
    logic [MAG_W:0] n_twice_x;
    logic [MAG_W:0] n_twice_y;
    assign n_twice_x = {r_x[DIV_STEPS-1].rem, 1'b0};
    assign n_twice_y = {r_y[DIV_STEPS-1].rem, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[DIV_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quo_x <= r_x[DIV_STEPS-1].qn
                + QUO_W'(n_twice_x >= {1'b0, r_den[DIV_STEPS-1]});
            o_quo_y <= r_y[DIV_STEPS-1].qn
                + QUO_W'(n_twice_y >= {1'b0, r_den[DIV_STEPS-1]});
            o_tag   <= r_tag[DIV_STEPS-1];
        end
    end

endmodule
`default_nettype wire

// ===== design/sidc_sqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sidc_sqrt (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_en,
    input  wire                           i_valid,
    input  wire [sidc_pkg::SQ_IN_W-1:0]   i_radicand,
    input  sidc_pkg::t_sqrt_tag           i_tag,
    output logic                          o_valid,
    output logic [sidc_pkg::DIST_W-1:0]   o_root,
    output sidc_pkg::t_sqrt_tag           o_tag
);
    import sidc_pkg::*;

    logic      r_v   [SQRT_STEPS];
    t_sqrt_st  r_st  [SQRT_STEPS];
    t_sqrt_tag r_tag [SQRT_STEPS];

    t_sqrt_st seed;
    assign seed = '{rem: '0, root: '0, rad: {1'b0, i_radicand}};

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= i_valid;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[k]  <= sqrt_step(seed);
                    r_tag[k] <= i_tag;
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_st[k]  <= sqrt_step(r_st[k-1]);
                    r_tag[k] <= r_tag[k-1];
                end
            end
        end
    end

    // round up when the remainder exceeds the floor root, then saturate
    logic [ROOT_W:0] n_round;
    assign n_round = {1'b0, r_st[SQRT_STEPS-1].root}
        + (ROOT_W+1)'(r_st[SQRT_STEPS-1].rem > REM_W'(r_st[SQRT_STEPS-1].root));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_root <= (n_round[ROOT_W:DIST_W] != '0) ? '1 : n_round[DIST_W-1:0];
            o_tag  <= r_tag[SQRT_STEPS-1];
        end
    end

endmodule
`default_nettype wire

// ===== design/segment_intersection_distance_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake                 Beat
// in        sink       i_in_valid / o_in_stall   t_in_item (two segments)
// out       source     o_out_valid / i_out_stall t_out_item (status, distance, point)
// cfg       APB slave  psel penable pwrite pready det_threshold at byte address 0
//
// One beat enters per cycle while o_in_stall is low; its result is offered after it passes
// stages 1-7, the divider, stages A and B, the square root and the output register.
// The pipeline holds the 32-step pipelined rounding divider and the 33-step
// pipelined square root, one result bit per stage.
// Synchronous active-low reset clears the valid bits and loads det_threshold = 4.
// A two-entry output (register plus skid) keeps intake open while one result waits;
// the whole pipeline holds only when the skid entry is occupied.
module segment_intersection_distance_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    input  sidc_pkg::t_in_item           i_in_data,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output sidc_pkg::t_out_item          o_out_data,
    input  wire                          i_out_stall,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [sidc_pkg::ADDR_W-1:0]   paddr,
    input  wire [31:0]                   pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import sidc_pkg::*;

    // ---------------- configuration ----------------
    logic [THR_W-1:0] r_thr;
    logic             cfg_hit;
    assign cfg_hit = (paddr[ADDR_W-1:2] == REG_DET_THRESHOLD);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? r_thr : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (psel && penable && pwrite && cfg_hit) begin
            r_thr <= pwdata;
        end
    end

    // ---------------- flow control ----------------
    // every stage advances together; hold only while the skid entry is full
    logic r_skid_v;
    logic en;
    assign en         = !r_skid_v;
    assign o_in_stall = !en;

    // ---------------- stage 1: edge vectors ----------------
    logic                       r1_v;
    logic signed [DIFF_W-1:0]   r1_dx, r1_dy, r1_fx, r1_fy, r1_bx, r1_by;
    logic [COORD_W-1:0]         r1_p0x, r1_p0y;

    function automatic logic signed [DIFF_W-1:0] sub33(logic [COORD_W-1:0] a,
                                                       logic [COORD_W-1:0] b);
        return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_dx  <= sub33(i_in_data.path_end_x, i_in_data.path_start_x);
            r1_dy  <= sub33(i_in_data.path_end_y, i_in_data.path_start_y);
            r1_fx  <= sub33(i_in_data.edge_start_x, i_in_data.edge_end_x);
            r1_fy  <= sub33(i_in_data.edge_start_y, i_in_data.edge_end_y);
            r1_bx  <= sub33(i_in_data.edge_start_x, i_in_data.path_start_x);
            r1_by  <= sub33(i_in_data.edge_start_y, i_in_data.path_start_y);
            r1_p0x <= i_in_data.path_start_x;
            r1_p0y <= i_in_data.path_start_y;
        end
    end

    // ---------------- stage 2: six cross products ----------------
    logic                       r2_v;
    logic signed [PROD_W-1:0]   r2_dxfy, r2_fxdy, r2_bxfy, r2_fxby, r2_dxby, r2_bxdy;
    logic [COORD_W-1:0]         r2_p0x, r2_p0y, r2_adx, r2_ady;
    logic                       r2_dx_neg, r2_dy_neg;

    logic signed [DIFF_W-1:0]   n_ndx, n_ndy;
    assign n_ndx = -r1_dx;
    assign n_ndy = -r1_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_dxfy   <= r1_dx * r1_fy;
            r2_fxdy   <= r1_fx * r1_dy;
            r2_bxfy   <= r1_bx * r1_fy;
            r2_fxby   <= r1_fx * r1_by;
            r2_dxby   <= r1_dx * r1_by;
            r2_bxdy   <= r1_bx * r1_dy;
            r2_p0x    <= r1_p0x;
            r2_p0y    <= r1_p0y;
            r2_dx_neg <= r1_dx[DIFF_W-1];
            r2_dy_neg <= r1_dy[DIFF_W-1];
            r2_adx    <= r1_dx[DIFF_W-1] ? n_ndx[COORD_W-1:0] : r1_dx[COORD_W-1:0];
            r2_ady    <= r1_dy[DIFF_W-1] ? n_ndy[COORD_W-1:0] : r1_dy[COORD_W-1:0];
        end
    end

    // ---------------- stage 3: Cramer numerators and determinant ----------------
    logic                       r3_v;
    logic signed [CROSS_W-1:0]  r3_det, r3_nt, r3_nu;
    logic [COORD_W-1:0]         r3_p0x, r3_p0y, r3_adx, r3_ady;
    logic                       r3_dx_neg, r3_dy_neg;

    function automatic logic signed [CROSS_W-1:0] xdiff(logic signed [PROD_W-1:0] a,
                                                        logic signed [PROD_W-1:0] b);
        return $signed({a[PROD_W-1], a}) - $signed({b[PROD_W-1], b});
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_det    <= xdiff(r2_dxfy, r2_fxdy);
            r3_nt     <= xdiff(r2_bxfy, r2_fxby);
            r3_nu     <= xdiff(r2_dxby, r2_bxdy);
            r3_p0x    <= r2_p0x;
            r3_p0y    <= r2_p0y;
            r3_adx    <= r2_adx;
            r3_ady    <= r2_ady;
            r3_dx_neg <= r2_dx_neg;
            r3_dy_neg <= r2_dy_neg;
        end
    end

    // ---------------- stage 4: make the determinant positive ----------------
    logic                       r4_v;
    logic signed [CROSS_W-1:0]  r4_det, r4_nt, r4_nu;
    logic [COORD_W-1:0]         r4_p0x, r4_p0y, r4_adx, r4_ady;
    logic                       r4_dx_neg, r4_dy_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r3_det[CROSS_W-1]) begin
                r4_det <= -r3_det;
                r4_nt  <= -r3_nt;
                r4_nu  <= -r3_nu;
            end else begin
                r4_det <= r3_det;
                r4_nt  <= r3_nt;
                r4_nu  <= r3_nu;
            end
            r4_p0x    <= r3_p0x;
            r4_p0y    <= r3_p0y;
            r4_adx    <= r3_adx;
            r4_ady    <= r3_ady;
            r4_dx_neg <= r3_dx_neg;
            r4_dy_neg <= r3_dy_neg;
        end
    end

    // ---------------- stage 5: parallel and range tests ----------------
    logic                  r5_v;
    t_status               r5_status;
    logic [MAG_W-1:0]      r5_det, r5_nt;
    logic [COORD_W-1:0]    r5_p0x, r5_p0y, r5_adx, r5_ady;
    logic                  r5_dx_neg, r5_dy_neg;
    t_status               n_status;

    // t = nt/det and u = nu/det must both land in [0, 1]; bounds count as a hit
    always_comb begin
        if (r4_det == '0 || r4_det < $signed({{(CROSS_W-THR_W){1'b0}}, r_thr})) begin
            n_status = ST_PARALLEL;
        end else if (r4_nt[CROSS_W-1] || r4_nt > r4_det
                     || r4_nu[CROSS_W-1] || r4_nu > r4_det) begin
            n_status = ST_OUTSIDE;
        end else begin
            n_status = ST_HIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_status <= n_status;
            r5_det    <= r4_det[MAG_W-1:0];
            r5_nt     <= r4_nt[MAG_W-1:0];
            r5_p0x    <= r4_p0x;
            r5_p0y    <= r4_p0y;
            r5_adx    <= r4_adx;
            r5_ady    <= r4_ady;
            r5_dx_neg <= r4_dx_neg;
            r5_dy_neg <= r4_dy_neg;
        end
    end

    // ---------------- stage 6: nt * |d| as partial products ----------------
    logic                          r6_v;
    logic [2*COORD_W-1:0]          r6_lo_x, r6_lo_y;
    logic [MAG_W-1:0]              r6_hi_x, r6_hi_y;
    logic [MAG_W-1:0]              r6_det;
    t_div_tag                      r6_tag;
    logic [MAG_W-COORD_W-1:0]      nt_hi;
    assign nt_hi = r5_nt[MAG_W-1:COORD_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_lo_x <= r5_nt[COORD_W-1:0] * r5_adx;
            r6_lo_y <= r5_nt[COORD_W-1:0] * r5_ady;
            r6_hi_x <= nt_hi * r5_adx;
            r6_hi_y <= nt_hi * r5_ady;
            r6_det  <= r5_det;
            r6_tag  <= '{status: r5_status, p0x: r5_p0x, p0y: r5_p0y,
                         dx_neg: r5_dx_neg, dy_neg: r5_dy_neg};
        end
    end

    // ---------------- stage 7: assemble numerators ----------------
    logic               r7_v;
    logic [NUM_W-1:0]   r7_num_x, r7_num_y;
    logic [MAG_W-1:0]   r7_det;
    t_div_tag           r7_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_num_x <= {r6_hi_x, {COORD_W{1'b0}}} + NUM_W'(r6_lo_x);
            r7_num_y <= {r6_hi_y, {COORD_W{1'b0}}} + NUM_W'(r6_lo_y);
            r7_det   <= r6_det;
            r7_tag   <= r6_tag;
        end
    end

    // ---------------- rounding divider: offsets along x and y ----------------
    logic               div_v;
    logic [QUO_W-1:0]   div_ox, div_oy;
    t_div_tag           div_tag;

    sidc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r7_v),
        .i_num_x (r7_num_x),
        .i_num_y (r7_num_y),
        .i_den   (r7_det),
        .i_tag   (r7_tag),
        .o_valid (div_v),
        .o_quo_x (div_ox),
        .o_quo_y (div_oy),
        .o_tag   (div_tag)
    );

    // ---------------- stage A: crossing point and squared offsets ----------------
    logic                   ra_v;
    logic [2*QUO_W-1:0]     ra_sq_x, ra_sq_y;
    t_sqrt_tag              ra_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            ra_v <= 1'b0;
        end else if (en) begin
            ra_v <= div_v;
        end
    end

    // the point lies between the path ends, so the 32-bit sum cannot wrap
    always_ff @(posedge i_clk) begin
        if (en) begin
            ra_sq_x <= div_ox * div_ox;
            ra_sq_y <= div_oy * div_oy;
            ra_tag  <= '{status:  div_tag.status,
                         cross_x: div_tag.dx_neg ? div_tag.p0x - div_ox
                                                 : div_tag.p0x + div_ox,
                         cross_y: div_tag.dy_neg ? div_tag.p0y - div_oy
                                                 : div_tag.p0y + div_oy};
        end
    end

    // ---------------- stage B: squared distance ----------------
    logic                 rb_v;
    logic [SQ_IN_W-1:0]   rb_sum;
    t_sqrt_tag            rb_tag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rb_v <= 1'b0;
        end else if (en) begin
            rb_v <= ra_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rb_sum <= SQ_IN_W'(ra_sq_x) + SQ_IN_W'(ra_sq_y);
            rb_tag <= ra_tag;
        end
    end

    // ---------------- rounding square root ----------------
    logic                sq_v;
    logic [DIST_W-1:0]   sq_dist;
    t_sqrt_tag           sq_tag;

    sidc_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (rb_v),
        .i_radicand (rb_sum),
        .i_tag      (rb_tag),
        .o_valid    (sq_v),
        .o_root     (sq_dist),
        .o_tag      (sq_tag)
    );

    // ---------------- output register and skid ----------------
    t_out_item n_result;
    always_comb begin
        n_result.status = sq_tag.status;
        if (sq_tag.status == ST_HIT) begin
            n_result.hit_distance = sq_dist;
            n_result.cross_x      = sq_tag.cross_x;
            n_result.cross_y      = sq_tag.cross_y;
        end else begin
            n_result.hit_distance = '0;
            n_result.cross_x      = '0;
            n_result.cross_y      = '0;
        end
    end

    logic      r_out_v;
    t_out_item r_out;
    t_out_item r_skid;
    logic      arrive;
    logic      take;
    assign arrive = sq_v && en;
    assign take   = r_out_v && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (take || !r_out_v) begin
            // refill from the skid first; the pipe is held while it is full
            r_out_v  <= r_skid_v || arrive;
            r_skid_v <= 1'b0;
        end else if (arrive) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take || !r_out_v) begin
            r_out <= r_skid_v ? r_skid : n_result;
        end else if (arrive) begin
            r_skid <= n_result;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // ---------------- checks ----------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid entry occupied with empty output register");

    a_no_hit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && r_out.status != ST_HIT) |->
            (r_out.hit_distance == '0 && r_out.cross_x == '0 && r_out.cross_y == '0))
        else $error("result fields not cleared without a hit");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_out_stall) |=> (r_out_v && $stable(r_out)))
        else $error("stalled result dropped or changed");

    a_skid_stops_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_v && i_out_stall) |=> r_skid_v && $stable(r_skid))
        else $error("skid entry lost while output stalled");

endmodule
`default_nettype wire
